/* sv/mmdc_pkg.sv */
// Package for the mesh message duplicate cache.
// Holds the entry field widths, the controller state type and the command and
// status structures shared by the controller and the datapath. No dependencies.
package mmdc_pkg;

    localparam int SRC_W   = 16;
    localparam int SEQ_W   = 24;
    localparam int ENTRY_W = SRC_W + SEQ_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPEND,
        ST_POST
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_key;   // latch the new identity and read slot 0
        logic scan_step;  // compare slot, write carry back, move to the next slot
        logic append;     // write carry into the first free slot
        logic mark_hit;   // the identity was found
        logic mark_evict; // the oldest entry fell off the end
        logic post;       // load the result register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;    // no valid entries
        logic match;    // slot being examined holds the identity
        logic last;     // slot being examined is the last valid one
        logic full;     // every slot is valid
        logic out_free; // result register can take a new result
    } stat_t;

endpackage

/* sv/mmdc_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module mmdc_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/mmdc_ctrl.sv */
// Controller state machine for the mesh message duplicate cache.
// Depends on mmdc_pkg for the state, command and status types.
module mmdc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  mmdc_pkg::stat_t stat,
    output mmdc_pkg::cmd_t  cmd
);

    mmdc_pkg::state_t state_reg;
    mmdc_pkg::state_t state_next;
    logic             accept;

    assign in_ready = (state_reg == mmdc_pkg::ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mmdc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mmdc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = stat.empty ? mmdc_pkg::ST_APPEND : mmdc_pkg::ST_SCAN;
                end
            end
            mmdc_pkg::ST_SCAN:
            begin
                if (stat.match)
                begin
                    state_next = mmdc_pkg::ST_POST;
                end
                else if (stat.last)
                begin
                    state_next = stat.full ? mmdc_pkg::ST_POST : mmdc_pkg::ST_APPEND;
                end
            end
            mmdc_pkg::ST_APPEND:
            begin
                state_next = mmdc_pkg::ST_POST;
            end
            mmdc_pkg::ST_POST:
            begin
                if (stat.out_free)
                begin
                    state_next = mmdc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mmdc_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            mmdc_pkg::ST_IDLE:
            begin
                cmd.load_key = accept;
            end
            mmdc_pkg::ST_SCAN:
            begin
                cmd.scan_step  = 1'b1;
                cmd.mark_hit   = stat.match;
                cmd.mark_evict = !stat.match && stat.last && stat.full;
            end
            mmdc_pkg::ST_APPEND:
            begin
                cmd.append = 1'b1;
            end
            mmdc_pkg::ST_POST:
            begin
                cmd.post = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* sv/mmdc_datapath.sv */
// Datapath for the mesh message duplicate cache: entry RAM, scan index, fill
// count, carry register and result register.
// Depends on mmdc_pkg and mmdc_ram.
module mmdc_datapath #(
    parameter int DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mmdc_pkg::cmd_t                cmd,
    output mmdc_pkg::stat_t               stat,
    input  logic [mmdc_pkg::SRC_W-1:0]    source_address,
    input  logic [mmdc_pkg::SEQ_W-1:0]    sequence_number,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          already_seen,
    output logic                          evicted_oldest
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [mmdc_pkg::ENTRY_W-1:0] key_reg;
    logic [mmdc_pkg::ENTRY_W-1:0] carry_reg;
    logic [mmdc_pkg::ENTRY_W-1:0] carry_next;
    logic [IDX_W-1:0]             idx_reg;
    logic [IDX_W-1:0]             idx_next;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic                         hit_reg;
    logic                         hit_next;
    logic                         evict_reg;
    logic                         evict_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         seen_reg;
    logic                         seen_next;
    logic                         evicted_reg;
    logic                         evicted_next;

    logic                         wr_en;
    logic [IDX_W-1:0]             wr_addr;
    logic                         rd_en;
    logic [IDX_W-1:0]             rd_addr;
    logic [mmdc_pkg::ENTRY_W-1:0] rd_data;
    logic [CNT_W-1:0]             idx_plus_one;

    mmdc_ram #(
        .WIDTH (mmdc_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (carry_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign idx_plus_one = CNT_W'(idx_reg) + CNT_W'(1);

    // Each slot is read before it is overwritten with its newer neighbour.
    assign rd_en   = cmd.load_key || cmd.scan_step;
    assign rd_addr = cmd.load_key ? '0 : idx_plus_one[IDX_W-1:0];
    assign wr_en   = cmd.scan_step || cmd.append;
    assign wr_addr = cmd.append ? count_reg[IDX_W-1:0] : idx_reg;

    assign stat.empty    = (count_reg == '0);
    assign stat.match    = (rd_data == key_reg);
    assign stat.last     = (idx_plus_one == count_reg);
    assign stat.full     = (count_reg == CNT_W'(DEPTH));
    assign stat.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        carry_next     = carry_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        hit_next       = hit_reg;
        evict_next     = evict_reg;
        out_valid_next = out_valid_reg;
        seen_next      = seen_reg;
        evicted_next   = evicted_reg;

        if (cmd.load_key)
        begin
            carry_next = {source_address, sequence_number};
            idx_next   = '0;
            hit_next   = 1'b0;
            evict_next = 1'b0;
        end
        if (cmd.scan_step)
        begin
            carry_next = rd_data;
            idx_next   = idx_plus_one[IDX_W-1:0];
        end
        if (cmd.append)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.mark_hit)
        begin
            hit_next = 1'b1;
        end
        if (cmd.mark_evict)
        begin
            evict_next = 1'b1;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.post)
        begin
            out_valid_next = 1'b1;
            seen_next      = hit_reg;
            evicted_next   = evict_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_key)
        begin
            key_reg <= {source_address, sequence_number};
        end
        carry_reg   <= carry_next;
        idx_reg     <= idx_next;
        hit_reg     <= hit_next;
        evict_reg   <= evict_next;
        seen_reg    <= seen_next;
        evicted_reg <= evicted_next;
    end

    assign out_valid      = out_valid_reg;
    assign already_seen   = seen_reg;
    assign evicted_oldest = evicted_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count exceeds cache depth");

    a_append_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |-> !stat.full)
        else $error("append into a full cache");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> (idx_plus_one <= count_reg))
        else $error("scan beyond the valid entries");

    a_post_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.post |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before it was taken");

    a_hit_evict_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.post |=> !(already_seen && evicted_oldest))
        else $error("duplicate reported together with an eviction");

endmodule

/* sv/mesh_message_duplicate_cache.sv */
// Mesh message duplicate cache: most-recently-seen list of message identities.
// Built from mmdc_ctrl (state machine) and mmdc_datapath (RAM and registers),
// both of which use mmdc_pkg.
//
// Usage
// The input channel (in_valid/in_ready) carries one message identity per
// transaction: a 16-bit source address and a 24-bit sequence number. The
// output channel (out_valid/out_ready) returns one transaction per input:
// already_seen is high when the identity was in the cache, evicted_oldest is
// high when a new identity pushed the oldest entry out of a full cache.
// The list is kept newest first in a single RAM of DEPTH entries. One pass
// walks the valid entries, one per cycle, comparing each and writing its
// newer neighbour back into its slot, so the move-to-front happens during
// the search itself.
// A hit ends the scan at its slot; a miss walks every valid entry and then
// either writes the last one into the first free slot or, on a full cache,
// drops it. The next identity is accepted in the cycle after the result is
// posted, so while the receiver takes each result the rate is set by the
// one-entry-per-cycle scan through the RAM read port.
// Reset clears the fill count, which empties the cache at once; no clearing
// pass is needed. A finished result waits in the output register while the
// receiver stalls, and a new identity can still be accepted and searched;
// only the posting of its result waits for the register to be taken.
module mesh_message_duplicate_cache #(
    parameter int DEPTH = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [mmdc_pkg::SRC_W-1:0] source_address,
    input  logic [mmdc_pkg::SEQ_W-1:0] sequence_number,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       already_seen,
    output logic                       evicted_oldest
);

    mmdc_pkg::cmd_t  cmd;
    mmdc_pkg::stat_t stat;

    // The controller sequences the search; it sees only status flags and in_valid.
    mmdc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the list, the fill count and the result register.
    mmdc_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .source_address  (source_address),
        .sequence_number (sequence_number),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .already_seen    (already_seen),
        .evicted_oldest  (evicted_oldest)
    );

endmodule
